### sv/jcfp_pkg.sv
// Package: phase codes, event kinds, error codes and helper functions for the class file parser.
`default_nettype none
package jcfp_pkg;
    localparam logic [4:0] PH_MAGIC  = 5'd0;
    localparam logic [4:0] PH_MINOR  = 5'd1;
    localparam logic [4:0] PH_MAJOR  = 5'd2;
    localparam logic [4:0] PH_PCNT   = 5'd3;
    localparam logic [4:0] PH_TAG    = 5'd4;
    localparam logic [4:0] PH_ENTRY  = 5'd5;
    localparam logic [4:0] PH_UTF8   = 5'd6;
    localparam logic [4:0] PH_ACCESS = 5'd7;
    localparam logic [4:0] PH_THIS   = 5'd8;
    localparam logic [4:0] PH_SUPER  = 5'd9;
    localparam logic [4:0] PH_ICNT   = 5'd10;
    localparam logic [4:0] PH_IFACE  = 5'd11;
    localparam logic [4:0] PH_FCNT   = 5'd12;
    localparam logic [4:0] PH_MACC   = 5'd13;
    localparam logic [4:0] PH_MNAME  = 5'd14;
    localparam logic [4:0] PH_MDESC  = 5'd15;
    localparam logic [4:0] PH_MACNT  = 5'd16;
    localparam logic [4:0] PH_MCNT   = 5'd17;
    localparam logic [4:0] PH_CACNT  = 5'd18;
    localparam logic [4:0] PH_ANAME  = 5'd19;
    localparam logic [4:0] PH_ALEN   = 5'd20;
    localparam logic [4:0] PH_ABYTE  = 5'd21;
    localparam logic [4:0] PH_DONE   = 5'd22;
    localparam logic [4:0] KIND_ERROR = 5'd22;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_TAG   = 2'd2;

    localparam logic [1:0] OWN_CLASS  = 2'd0;
    localparam logic [1:0] OWN_FIELD  = 2'd1;
    localparam logic [1:0] OWN_METHOD = 2'd2;

    localparam logic [7:0]  TAG_UTF8    = 8'd1;
    localparam logic [7:0]  TAG_INT     = 8'd3;
    localparam logic [7:0]  TAG_FLOAT   = 8'd4;
    localparam logic [7:0]  TAG_LONG    = 8'd5;
    localparam logic [7:0]  TAG_DOUBLE  = 8'd6;
    localparam logic [7:0]  TAG_MHANDLE = 8'd15;
    localparam logic [31:0] CLASS_MAGIC = 32'hCAFEBABE;

    // one result event
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [1:0]  owner;
        logic [15:0] member_index;
        logic [15:0] entry_index;
        logic [31:0] sub_index;
        logic [1:0]  error;
        logic        done_res;
    } t_event;

    // number of fields in a pool entry; zero marks a bad tag
    function automatic logic [1:0] entry_fields(input logic [7:0] tag);
        logic [1:0] n;
        unique case (tag)
            8'd1, 8'd3, 8'd4, 8'd7, 8'd8, 8'd16: n = 2'd1;
            8'd5, 8'd6, 8'd9, 8'd10, 8'd11, 8'd12, 8'd15, 8'd18: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction
endpackage
`default_nettype wire

### sv/java_class_file_stream_parser.sv
// Top level: streaming Java class file parser, one byte per cycle.
// An event is registered in the output stage once the byte that completes its field is accepted.
// Throughput: one byte per cycle while input ready is high; the parser core updates all state on each accepted byte.
// Input ready drops only while the two-entry output stage is full.
// Reset (synchronous, active low) returns to the magic phase and empties the output stage.
`default_nettype none
module java_class_file_stream_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_kind,
    output logic [31:0]      o_value,
    output logic [1:0]       o_owner,
    output logic [15:0]      o_member_index,
    output logic [15:0]      o_entry_index,
    output logic [31:0]      o_sub_index,
    output logic [1:0]       o_error,
    output logic             o_done_res
);
    jcfp_pkg::t_event evt, out_evt;
    logic evt_valid, can_push, step;

    assign o_ready = can_push;
    assign step    = i_valid && can_push;

    jcfp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_data_byte(i_data_byte), .i_first_byte(i_first_byte),
        .o_evt(evt), .o_evt_valid(evt_valid)
    );

    jcfp_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(step && evt_valid), .i_evt(evt),
        .o_can_push(can_push), .o_valid(o_valid), .i_ready(i_ready), .o_evt(out_evt)
    );

    assign o_kind         = out_evt.kind;
    assign o_value        = out_evt.value;
    assign o_owner        = out_evt.owner;
    assign o_member_index = out_evt.member_index;
    assign o_entry_index  = out_evt.entry_index;
    assign o_sub_index    = out_evt.sub_index;
    assign o_error        = out_evt.error;
    assign o_done_res     = out_evt.done_res;
endmodule
`default_nettype wire

### sv/jcfp_core.sv
// Parser core: field assembly, phase walk and event generation, one byte per cycle while i_step is high.
`default_nettype none
module jcfp_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_first_byte,
    output jcfp_pkg::t_event     o_evt,
    output logic                 o_evt_valid
);
    logic [4:0]  r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [2:0]  r_seen, n_seen;
    logic [15:0] r_pool_total, n_pool_total;
    logic [15:0] r_pool_num, n_pool_num;
    logic [7:0]  r_tag, n_tag;
    logic [1:0]  r_efield, n_efield;
    logic [15:0] r_utf8_left, n_utf8_left;
    logic [15:0] r_list_left, n_list_left;
    logic [15:0] r_member, n_member;
    logic [1:0]  r_owner, n_owner;
    logic [15:0] r_attrs_left, n_attrs_left;
    logic [15:0] r_attr_num, n_attr_num;
    logic [31:0] r_abytes_left, n_abytes_left;
    logic        r_halted, n_halted;
    logic [31:0] r_offset, n_offset;

    // state after an optional restart
    logic [4:0]  s_phase;
    logic [31:0] s_shift;
    logic [2:0]  s_seen;
    logic        s_halted;
    logic [2:0]  width;
    logic [31:0] v;
    logic [2:0]  seen_inc;
    logic [16:0] step_sum;
    logic [15:0] list_dec, attrs_dec;
    logic [31:0] abytes_dec;
    logic [15:0] start_cnt;
    logic        complete;

    assign s_phase  = i_first_byte ? jcfp_pkg::PH_MAGIC : r_phase;
    assign s_shift  = i_first_byte ? 32'd0 : r_shift;
    assign s_seen   = i_first_byte ? 3'd0 : r_seen;
    assign s_halted = i_first_byte ? 1'b0 : r_halted;
    assign v        = {s_shift[23:0], i_data_byte};
    assign seen_inc = s_seen + 3'd1;
    assign list_dec   = r_list_left - 16'd1;
    assign attrs_dec  = r_attrs_left - 16'd1;
    assign abytes_dec = r_abytes_left - 32'd1;
    assign start_cnt  = v[15:0];

    // width of the field in the current phase
    always_comb begin
        unique case (s_phase)
            jcfp_pkg::PH_MAGIC, jcfp_pkg::PH_ALEN: width = 3'd4;
            jcfp_pkg::PH_TAG, jcfp_pkg::PH_UTF8, jcfp_pkg::PH_ABYTE: width = 3'd1;
            jcfp_pkg::PH_ENTRY: begin
                if (r_tag == jcfp_pkg::TAG_INT || r_tag == jcfp_pkg::TAG_FLOAT
                    || r_tag == jcfp_pkg::TAG_LONG || r_tag == jcfp_pkg::TAG_DOUBLE)
                    width = 3'd4;
                else if (r_tag == jcfp_pkg::TAG_MHANDLE && r_efield == 2'd0)
                    width = 3'd1;
                else
                    width = 3'd2;
            end
            default: width = 3'd2;
        endcase
    end

    assign complete = !s_halted && s_phase != jcfp_pkg::PH_DONE && seen_inc >= width;

    // next state and event
    always_comb begin
        n_phase = s_phase; n_shift = s_shift; n_seen = s_seen;
        n_pool_total = r_pool_total; n_pool_num = r_pool_num; n_tag = r_tag;
        n_efield = r_efield; n_utf8_left = r_utf8_left; n_list_left = r_list_left;
        n_member = r_member; n_owner = r_owner; n_attrs_left = r_attrs_left;
        n_attr_num = r_attr_num; n_abytes_left = r_abytes_left;
        n_halted = s_halted; n_offset = r_offset;
        step_sum = 17'd0;
        o_evt = '0;
        o_evt_valid = 1'b0;
        if (i_first_byte) begin
            n_pool_total = '0; n_pool_num = '0; n_tag = '0; n_efield = '0;
            n_utf8_left = '0; n_list_left = '0; n_member = '0; n_owner = '0;
            n_attrs_left = '0; n_attr_num = '0; n_abytes_left = '0; n_offset = '0;
        end
        if (!s_halted && s_phase != jcfp_pkg::PH_DONE) begin
            if (!complete) begin
                n_shift = v;
                n_seen = seen_inc;
            end else begin
                n_shift = '0;
                n_seen = '0;
                o_evt_valid = 1'b1;
                o_evt.kind = s_phase;
                o_evt.value = v;
                unique case (s_phase)
                    jcfp_pkg::PH_MAGIC: begin
                        if (v != jcfp_pkg::CLASS_MAGIC) begin
                            o_evt.kind = jcfp_pkg::KIND_ERROR;
                            o_evt.error = jcfp_pkg::ERR_MAGIC;
                            n_halted = 1'b1;
                        end else n_phase = jcfp_pkg::PH_MINOR;
                    end
                    jcfp_pkg::PH_MINOR: n_phase = jcfp_pkg::PH_MAJOR;
                    jcfp_pkg::PH_MAJOR: n_phase = jcfp_pkg::PH_PCNT;
                    jcfp_pkg::PH_PCNT: begin
                        n_pool_total = v[15:0];
                        n_pool_num = 16'd1;
                        n_phase = (v[15:0] <= 16'd1) ? jcfp_pkg::PH_ACCESS : jcfp_pkg::PH_TAG;
                    end
                    jcfp_pkg::PH_TAG: begin
                        o_evt.entry_index = r_pool_num;
                        n_tag = v[7:0];
                        n_efield = 2'd0;
                        if (jcfp_pkg::entry_fields(v[7:0]) == 2'd0) begin
                            o_evt.kind = jcfp_pkg::KIND_ERROR;
                            o_evt.error = jcfp_pkg::ERR_TAG;
                            step_sum = {1'b0, r_pool_num} + 17'd1;
                        end else n_phase = jcfp_pkg::PH_ENTRY;
                    end
                    jcfp_pkg::PH_ENTRY: begin
                        o_evt.entry_index = r_pool_num;
                        o_evt.sub_index = {30'd0, r_efield};
                        if (r_tag == jcfp_pkg::TAG_UTF8) begin
                            n_utf8_left = v[15:0];
                            n_offset = '0;
                            if (v[15:0] == 16'd0) step_sum = {1'b0, r_pool_num} + 17'd1;
                            else n_phase = jcfp_pkg::PH_UTF8;
                        end else if ({1'b0, r_efield} + 3'd1
                                     < {1'b0, jcfp_pkg::entry_fields(r_tag)}) begin
                            n_efield = r_efield + 2'd1;
                        end else if (r_tag == jcfp_pkg::TAG_LONG
                                     || r_tag == jcfp_pkg::TAG_DOUBLE) begin
                            step_sum = {1'b0, r_pool_num} + 17'd2;
                        end else step_sum = {1'b0, r_pool_num} + 17'd1;
                    end
                    jcfp_pkg::PH_UTF8: begin
                        o_evt.entry_index = r_pool_num;
                        o_evt.sub_index = r_offset;
                        n_offset = r_offset + 32'd1;
                        n_utf8_left = r_utf8_left - 16'd1;
                        if (r_utf8_left == 16'd1) step_sum = {1'b0, r_pool_num} + 17'd1;
                    end
                    jcfp_pkg::PH_ACCESS: n_phase = jcfp_pkg::PH_THIS;
                    jcfp_pkg::PH_THIS: n_phase = jcfp_pkg::PH_SUPER;
                    jcfp_pkg::PH_SUPER: n_phase = jcfp_pkg::PH_ICNT;
                    jcfp_pkg::PH_ICNT: begin
                        n_list_left = v[15:0];
                        n_attr_num = '0;
                        n_phase = (v[15:0] == 16'd0) ? jcfp_pkg::PH_FCNT : jcfp_pkg::PH_IFACE;
                    end
                    jcfp_pkg::PH_IFACE: begin
                        o_evt.entry_index = r_attr_num;
                        n_attr_num = r_attr_num + 16'd1;
                        n_list_left = list_dec;
                        if (list_dec == 16'd0) n_phase = jcfp_pkg::PH_FCNT;
                    end
                    jcfp_pkg::PH_FCNT, jcfp_pkg::PH_MCNT: begin
                        if (start_cnt == 16'd0) begin
                            n_phase = (s_phase == jcfp_pkg::PH_FCNT)
                                ? jcfp_pkg::PH_MCNT : jcfp_pkg::PH_CACNT;
                        end else begin
                            n_list_left = start_cnt;
                            n_member = '0;
                            n_owner = (s_phase == jcfp_pkg::PH_FCNT)
                                ? jcfp_pkg::OWN_FIELD : jcfp_pkg::OWN_METHOD;
                            n_phase = jcfp_pkg::PH_MACC;
                        end
                    end
                    jcfp_pkg::PH_MACC, jcfp_pkg::PH_MNAME, jcfp_pkg::PH_MDESC: begin
                        o_evt.owner = r_owner;
                        o_evt.member_index = r_member;
                        n_phase = s_phase + 5'd1;
                    end
                    jcfp_pkg::PH_MACNT, jcfp_pkg::PH_CACNT: begin
                        if (s_phase == jcfp_pkg::PH_MACNT) begin
                            o_evt.owner = r_owner;
                            o_evt.member_index = r_member;
                        end else begin
                            n_owner = jcfp_pkg::OWN_CLASS;
                            n_member = '0;
                        end
                        n_attrs_left = start_cnt;
                        n_attr_num = '0;
                        if (start_cnt != 16'd0) n_phase = jcfp_pkg::PH_ANAME;
                        else if (s_phase == jcfp_pkg::PH_CACNT
                                 || r_owner == jcfp_pkg::OWN_CLASS) begin
                            n_phase = jcfp_pkg::PH_DONE;
                            o_evt.done_res = 1'b1;
                        end else begin
                            n_list_left = list_dec;
                            if (list_dec == 16'd0)
                                n_phase = (r_owner == jcfp_pkg::OWN_FIELD)
                                    ? jcfp_pkg::PH_MCNT : jcfp_pkg::PH_CACNT;
                            else begin
                                n_member = r_member + 16'd1;
                                n_phase = jcfp_pkg::PH_MACC;
                            end
                        end
                    end
                    jcfp_pkg::PH_ANAME, jcfp_pkg::PH_ALEN, jcfp_pkg::PH_ABYTE: begin
                        o_evt.owner = r_owner;
                        o_evt.member_index = r_member;
                        o_evt.entry_index = r_attr_num;
                        if (s_phase == jcfp_pkg::PH_ANAME) n_phase = jcfp_pkg::PH_ALEN;
                        else if (s_phase == jcfp_pkg::PH_ALEN && v != 32'd0) begin
                            n_abytes_left = v;
                            n_offset = '0;
                            n_phase = jcfp_pkg::PH_ABYTE;
                        end else if (s_phase == jcfp_pkg::PH_ABYTE && abytes_dec != 32'd0) begin
                            o_evt.sub_index = r_offset;
                            n_offset = r_offset + 32'd1;
                            n_abytes_left = abytes_dec;
                        end else begin
                            // attribute finished
                            if (s_phase == jcfp_pkg::PH_ABYTE) begin
                                o_evt.sub_index = r_offset;
                                n_offset = r_offset + 32'd1;
                                n_abytes_left = abytes_dec;
                            end else begin
                                n_abytes_left = v;
                                n_offset = '0;
                            end
                            n_attrs_left = attrs_dec;
                            n_attr_num = r_attr_num + 16'd1;
                            if (attrs_dec != 16'd0) n_phase = jcfp_pkg::PH_ANAME;
                            else if (r_owner == jcfp_pkg::OWN_CLASS) begin
                                n_phase = jcfp_pkg::PH_DONE;
                                o_evt.done_res = 1'b1;
                            end else begin
                                n_list_left = list_dec;
                                if (list_dec == 16'd0)
                                    n_phase = (r_owner == jcfp_pkg::OWN_FIELD)
                                        ? jcfp_pkg::PH_MCNT : jcfp_pkg::PH_CACNT;
                                else begin
                                    n_member = r_member + 16'd1;
                                    n_phase = jcfp_pkg::PH_MACC;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                // pool entry finished
                if (step_sum != 17'd0) begin
                    n_pool_num = step_sum[15:0];
                    n_phase = (step_sum >= {1'b0, r_pool_total})
                        ? jcfp_pkg::PH_ACCESS : jcfp_pkg::PH_TAG;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jcfp_pkg::PH_MAGIC; r_shift <= '0; r_seen <= '0;
            r_pool_total <= '0; r_pool_num <= '0; r_tag <= '0; r_efield <= '0;
            r_utf8_left <= '0; r_list_left <= '0; r_member <= '0; r_owner <= '0;
            r_attrs_left <= '0; r_attr_num <= '0; r_abytes_left <= '0;
            r_halted <= 1'b0; r_offset <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_shift <= n_shift; r_seen <= n_seen;
            r_pool_total <= n_pool_total; r_pool_num <= n_pool_num; r_tag <= n_tag;
            r_efield <= n_efield; r_utf8_left <= n_utf8_left; r_list_left <= n_list_left;
            r_member <= n_member; r_owner <= n_owner; r_attrs_left <= n_attrs_left;
            r_attr_num <= n_attr_num; r_abytes_left <= n_abytes_left;
            r_halted <= n_halted; r_offset <= n_offset;
        end
    end

    // a halted parser never leaves the magic phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_phase == jcfp_pkg::PH_MAGIC)
        else $error("halted outside magic phase");
    // partial field never reaches four bytes
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_seen < 3'd4)
        else $error("field byte count overflow");
    // completion event only when entering done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_evt_valid && o_evt.done_res) |=> r_phase == jcfp_pkg::PH_DONE)
        else $error("done event without done phase");
endmodule
`default_nettype wire

### sv/jcfp_out_reg.sv
// Output register with skid stage for result events.
`default_nettype none
module jcfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jcfp_pkg::t_event  i_evt,
    output logic                   o_can_push,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output jcfp_pkg::t_event       o_evt
);
    logic            r_valid, r_skid_valid;
    jcfp_pkg::t_event r_evt, r_skid;
    logic            pop;

    assign pop        = r_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_valid;
    assign o_evt      = r_evt;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || pop) begin
                r_valid <= r_skid_valid || i_push;
                r_skid_valid <= r_skid_valid && i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_valid || pop) begin
            r_evt <= r_skid_valid ? r_skid : i_evt;
            if (r_skid_valid) r_skid <= i_evt;
        end else if (i_push) begin
            r_skid <= i_evt;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_skid_valid |-> r_valid)
        else $error("skid full with empty output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> r_skid_valid)
        else $error("skid entry lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("push into full stage");
endmodule
`default_nettype wire
